[rtl/core/assert_macros.svh]
// -----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the ready list; empty under synthesis.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define RRL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define RRL_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define RRL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define RRL_ASSERT(lbl, clk, rst, prop, msg)
`define RRL_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define RRL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/core/rrl_pkg.sv]
// -----------------------------------------------------------------------------
// Ready list package
// Shared constants, operation and status codes and the result type.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrl_pkg;

   localparam int DEF_LIST_DEPTH = 64;
   localparam int DEF_ID_BITS    = 16;

   localparam int ID_FIELD_BITS  = 16;
   localparam int OP_BITS        = 2;
   localparam int STATUS_BITS    = 2;
   localparam int OCC_BITS       = 7;

   localparam logic [OP_BITS-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_SELECT = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_MISSING = 2'd3;

   typedef struct packed {
      logic [ID_FIELD_BITS-1:0] chosen_id;
      logic [STATUS_BITS-1:0]   status;
      logic [OCC_BITS-1:0]      occupancy;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/rrl_ram.sv]
// -----------------------------------------------------------------------------
// Ready list storage
// Single write port, single read port memory with registered read data.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrl_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/rrl_ctrl.sv]
// -----------------------------------------------------------------------------
// Ready list sequencer
// Circular list pointers, scan compare and compaction steps over one RAM.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rrl_ctrl
   import rrl_pkg::*;
#(
   parameter int LIST_DEPTH = DEF_LIST_DEPTH,
   parameter int ENTRY_BITS = DEF_ID_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [OP_BITS-1:0]            req_op,
   input  wire logic [ENTRY_BITS-1:0]         req_id,
   output logic                               ram_wr_en,
   output logic      [$clog2(LIST_DEPTH)-1:0] ram_wr_addr,
   output logic      [ENTRY_BITS-1:0]         ram_wr_data,
   output logic      [$clog2(LIST_DEPTH)-1:0] ram_rd_addr,
   input  wire logic [ENTRY_BITS-1:0]         ram_rd_data,
   output logic                               res_valid,
   input  wire logic                          res_take,
   output result_type                         res
);

   localparam int AW = $clog2(LIST_DEPTH);
   localparam int CW = $clog2(LIST_DEPTH + 1);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SELECT   = 6'b000010,
      S_SCAN     = 6'b000100,
      S_SHIFT_WR = 6'b001000,
      S_SHIFT_RD = 6'b010000,
      S_EMIT     = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     tail_ff, tail_in;
   logic [AW-1:0]     cur_ff, cur_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic [ENTRY_BITS-1:0] id_ff, id_in;
   result_type        res_ff, res_in;

   logic [AW-1:0]     head_nxt, tail_nxt, tail_prv, cur_nxt;
   logic              list_full, list_empty, last_one;

   assign head_nxt   = (head_ff == AW'(LIST_DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign tail_nxt   = (tail_ff == AW'(LIST_DEPTH - 1)) ? '0 : tail_ff + AW'(1);
   assign tail_prv   = (tail_ff == '0) ? AW'(LIST_DEPTH - 1) : tail_ff - AW'(1);
   assign cur_nxt    = (cur_ff == AW'(LIST_DEPTH - 1)) ? '0 : cur_ff + AW'(1);
   assign list_full  = (count_ff == CW'(LIST_DEPTH));
   assign list_empty = (count_ff == '0);
   assign last_one   = (rem_ff == CW'(1));

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_EMIT);
   assign res       = res_ff;

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      cur_in      = cur_ff;
      count_in    = count_ff;
      rem_in      = rem_ff;
      id_in       = id_ff;
      res_in      = res_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = tail_ff;
      ram_wr_data = id_ff;
      ram_rd_addr = head_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               id_in            = req_id;
               res_in.chosen_id = '0;
               res_in.status    = ST_OK;
               res_in.occupancy = OCC_BITS'(count_ff);
               state_in         = S_EMIT;
               case (req_op)
                  OP_ADD: begin
                     if (list_full) begin
                        res_in.status = ST_FULL;
                     end else begin
                        ram_wr_en        = 1'b1;
                        ram_wr_data      = req_id;
                        tail_in          = tail_nxt;
                        count_in         = count_ff + CW'(1);
                        res_in.occupancy = OCC_BITS'(count_ff + CW'(1));
                     end
                  end
                  OP_REMOVE: begin
                     if (list_empty) begin
                        res_in.status = ST_MISSING;
                     end else begin
                        cur_in   = head_ff;
                        rem_in   = count_ff;
                        state_in = S_SCAN;
                     end
                  end
                  OP_SELECT: begin
                     if (list_empty) begin
                        res_in.status = ST_EMPTY;
                     end else begin
                        state_in = S_SELECT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SELECT: begin
            ram_wr_en        = 1'b1;
            ram_wr_data      = ram_rd_data;
            head_in          = head_nxt;
            tail_in          = tail_nxt;
            res_in.chosen_id = ID_FIELD_BITS'(ram_rd_data);
            state_in         = S_EMIT;
         end
         S_SCAN: begin
            ram_rd_addr = cur_nxt;
            if (ram_rd_data == id_ff) begin
               if (last_one) begin
                  tail_in          = tail_prv;
                  count_in         = count_ff - CW'(1);
                  res_in.occupancy = OCC_BITS'(count_ff - CW'(1));
                  state_in         = S_EMIT;
               end else begin
                  rem_in   = rem_ff - CW'(1);
                  state_in = S_SHIFT_WR;
               end
            end else if (last_one) begin
               res_in.status = ST_MISSING;
               state_in      = S_EMIT;
            end else begin
               cur_in = cur_nxt;
               rem_in = rem_ff - CW'(1);
            end
         end
         S_SHIFT_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cur_ff;
            ram_wr_data = ram_rd_data;
            cur_in      = cur_nxt;
            if (last_one) begin
               tail_in          = tail_prv;
               count_in         = count_ff - CW'(1);
               res_in.occupancy = OCC_BITS'(count_ff - CW'(1));
               state_in         = S_EMIT;
            end else begin
               rem_in   = rem_ff - CW'(1);
               state_in = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            ram_rd_addr = cur_nxt;
            state_in    = S_SHIFT_WR;
         end
         S_EMIT: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rem_ff <= rem_in;
      id_ff  <= id_in;
      res_ff <= res_in;
   end

   `RRL_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(LIST_DEPTH), "occupancy beyond depth")
   `RRL_ASSERT_IMPL(a_empty_ptrs, clock, reset, list_empty, head_ff == tail_ff, "ptrs apart")
   `RRL_ASSERT_IMPL(a_full_ptrs, clock, reset, list_full, head_ff == tail_ff, "ptrs apart")
   `RRL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "busy")

endmodule

`default_nettype wire

[rtl/core/round_robin_ready_list_top.sv]
// -----------------------------------------------------------------------------
// Round-robin ready list
// Ordered identifier list with add, remove-with-compaction and select-rotate.
// -----------------------------------------------------------------------------
//   channel  direction  tdata                          tuser
//   req      in         entry_id[15:0]                 op[1:0]
//   rsp      out        chosen_id[15:0], occupancy     status[1:0]
//
// Add, unused codes and empty-list cases go straight from accept to the result
// state; select passes through the S_SELECT read step first. Remove makes one
// compare per entry up to the match on the single memory read port, then write
// and read steps to move each later entry. One transaction is in work at a
// time; a finished result sits in the output register while the next request is
// taken. Synchronous active-high reset empties the list; contents are not cleared.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module round_robin_ready_list_top
   import rrl_pkg::*;
#(
   parameter int LIST_DEPTH = DEF_LIST_DEPTH,
   parameter int ID_BITS    = DEF_ID_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // entry_id[15:0]
   input  wire logic [1:0]  req_tuser,   // op[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata,   // chosen_id[15:0], occupancy[22:16], zero[23]
   output logic      [1:0]  rsp_tuser    // status[1:0]
);

   localparam int STORE_BITS = (ID_BITS < ID_FIELD_BITS) ? ID_BITS : ID_FIELD_BITS;
   localparam int AW         = $clog2(LIST_DEPTH);

   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
   logic [STORE_BITS-1:0] ram_wr_data, ram_rd_data;
   logic                  res_valid, res_take;
   result_type            res;

   logic                  out_valid_ff, out_valid_in;
   result_type            out_data_ff;

   rrl_ram #(
      .DEPTH (LIST_DEPTH),
      .WIDTH (STORE_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rrl_ctrl #(
      .LIST_DEPTH (LIST_DEPTH),
      .ENTRY_BITS (STORE_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser),
      .req_id      (req_tdata[STORE_BITS-1:0]),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .res         (res)
   );

   assign res_take = res_valid && (!out_valid_ff || rsp_tready);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (res_take) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         out_data_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_data_ff.occupancy, out_data_ff.chosen_id};
   assign rsp_tuser  = out_data_ff.status;

endmodule

`default_nettype wire

[tb/tb_round_robin_ready_list_top.sv]
// -----------------------------------------------------------------------------
// Round-robin ready list testbench
// Drives add, remove, select and unused-code transactions through the request
// stream and checks every response, field by field, against a preset result or
// a shadow copy of the list kept in the bench. A short table of directed steps
// covers the empty and edge cases, then random bursts fill, drain and mix the
// list under four idling patterns on both streams.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_round_robin_ready_list_top;
   import rrl_pkg::*;

   localparam int               LIST_DEPTH   = DEF_LIST_DEPTH;
   localparam logic [15:0]      ID_MASK      = (DEF_ID_BITS >= 16) ? 16'hFFFF :
                                               16'((32'd1 << DEF_ID_BITS) - 1);
   localparam logic [OP_BITS-1:0] OP_UNUSED  = 2'd3;
   localparam int               ITEMS_PER_PHASE = 250;
   localparam int               TAIL_CYCLES  = 250;

   typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIX} burst_kind_type;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic [15:0]        entry_id;
      logic               preset;
      result_type         want;
   } list_step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = 16'h0000;   // entry_id[15:0]
   logic [1:0]  req_tuser = OP_ADD;     // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;              // chosen_id[15:0], occupancy[22:16], zero[23]
   logic [1:0]  rsp_tuser;              // status[1:0]

   logic [15:0]   shadow_ids [LIST_DEPTH];
   int            shadow_count = 0;
   result_type    list_results_q [$];
   result_type    want_result;
   int            fail_count = 0;
   int            tx_idle_pct = 0;
   int            rx_stall_pct = 0;
   int            items_sent = 0;
   list_step_type directed_steps [20];

   round_robin_ready_list_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   function automatic void shadow_close_gap(input int pos);
      int j;
      for (j = pos; j + 1 < shadow_count; j++) begin
         shadow_ids[j] = shadow_ids[j + 1];
      end
   endfunction

   function automatic result_type ready_list_apply(input logic [OP_BITS-1:0] op,
                                                   input logic [15:0] raw_id);
      result_type  r;
      logic [15:0] id;
      bit          hit;
      int          k;
      r = '0;
      id = raw_id & ID_MASK;
      case (op)
         OP_ADD: begin
            if (shadow_count >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_ids[shadow_count] = id;
               shadow_count++;
            end
         end
         OP_REMOVE: begin
            hit = 1'b0;
            for (k = 0; k < shadow_count && !hit; k++) begin
               if (shadow_ids[k] == id) begin
                  hit = 1'b1;
                  shadow_close_gap(k);
                  shadow_count--;
               end
            end
            r.status = hit ? ST_OK : ST_MISSING;
         end
         OP_SELECT: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.chosen_id = shadow_ids[0];
               shadow_close_gap(0);
               shadow_ids[shadow_count - 1] = r.chosen_id;
            end
         end
         default: ;
      endcase
      r.occupancy = 7'(shadow_count);
      return r;
   endfunction

   function automatic bit id_listed(input logic [15:0] id);
      int k;
      for (k = 0; k < shadow_count; k++) begin
         if (shadow_ids[k] == id) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [15:0] pick_id();
      int roll;
      roll = $urandom_range(99);
      if (roll < 25) return 16'($urandom_range(7));
      if (roll < 31) return 16'hFFFF;
      if (roll < 37) return 16'h0000;
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] absent_id();
      logic [15:0] id;
      id = 16'($urandom);
      while (id_listed(id)) id = 16'($urandom);
      return id;
   endfunction

   function automatic logic [15:0] listed_id();
      return shadow_ids[$urandom_range(shadow_count - 1)];
   endfunction

   task automatic send_request(input logic [OP_BITS-1:0] op, input logic [15:0] id,
                               input bit preset, input result_type preset_result);
      result_type predicted;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 16'($urandom);
         req_tuser  <= 2'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= id;
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = ready_list_apply(op, id);
      list_results_q = {list_results_q, (preset ? preset_result : predicted)};
      items_sent++;
   endtask

   task automatic send_op(input logic [OP_BITS-1:0] op, input logic [15:0] id);
      send_request(op, id, 1'b0, '0);
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (list_results_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (list_results_q.size() == 0) begin
            $display("%0t unexpected response: expected none, got tdata %h tuser %h",
                     $time, rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want_result = list_results_q.pop_front();
            if (rsp_tdata[15:0] !== want_result.chosen_id) begin
               $display("%0t chosen_id: expected %h, got %h",
                        $time, want_result.chosen_id, rsp_tdata[15:0]);
               fail_count++;
            end
            if (rsp_tuser !== want_result.status) begin
               $display("%0t status: expected %0d, got %0d",
                        $time, want_result.status, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[22:16] !== want_result.occupancy) begin
               $display("%0t occupancy: expected %0d, got %0d",
                        $time, want_result.occupancy, rsp_tdata[22:16]);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int             phase;
      int             target;
      int             n;
      int             roll;
      burst_kind_type kind;
      int             tx_idle_by_phase [4];
      int             rx_stall_by_phase [4];

      tx_idle_by_phase  = '{0, 70, 0, 8};
      rx_stall_by_phase = '{0, 0, 70, 8};

      directed_steps = '{
         '{OP_SELECT, 16'h0000, 1'b1, '{16'h0000, ST_EMPTY,   7'd0}},
         '{OP_REMOVE, 16'h0000, 1'b1, '{16'h0000, ST_MISSING, 7'd0}},
         '{OP_UNUSED, 16'hFFFF, 1'b1, '{16'h0000, ST_OK,      7'd0}},
         '{OP_ADD,    16'hFFFF, 1'b1, '{16'h0000, ST_OK,      7'd1}},
         '{OP_ADD,    16'h0000, 1'b1, '{16'h0000, ST_OK,      7'd2}},
         '{OP_ADD,    16'hFFFF, 1'b1, '{16'h0000, ST_OK,      7'd3}},
         '{OP_ADD,    16'h8001, 1'b0, '0},
         '{OP_SELECT, 16'h1234, 1'b1, '{16'hFFFF, ST_OK,      7'd4}},
         '{OP_REMOVE, 16'hFFFF, 1'b0, '0},
         '{OP_REMOVE, 16'h1234, 1'b1, '{16'h0000, ST_MISSING, 7'd3}},
         '{OP_SELECT, 16'hFFFF, 1'b0, '0},
         '{OP_SELECT, 16'h0000, 1'b0, '0},
         '{OP_REMOVE, 16'h8001, 1'b0, '0},
         '{OP_REMOVE, 16'hFFFF, 1'b0, '0},
         '{OP_UNUSED, 16'h5A5A, 1'b1, '{16'h0000, ST_OK,      7'd1}},
         '{OP_REMOVE, 16'h0000, 1'b1, '{16'h0000, ST_OK,      7'd0}},
         '{OP_SELECT, 16'hA5A5, 1'b1, '{16'h0000, ST_EMPTY,   7'd0}},
         '{OP_ADD,    16'h7FFF, 1'b0, '0},
         '{OP_REMOVE, 16'h7FFF, 1'b0, '0},
         '{OP_REMOVE, 16'h7FFF, 1'b0, '0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i]) begin
         send_request(directed_steps[i].op, directed_steps[i].entry_id,
                      directed_steps[i].preset, directed_steps[i].want);
      end
      wait_results_drained();

      for (phase = 0; phase < 4; phase++) begin
         tx_idle_pct  = tx_idle_by_phase[phase];
         rx_stall_pct = rx_stall_by_phase[phase];
         target = items_sent + ITEMS_PER_PHASE;
         kind = BURST_FILL;
         while (items_sent < target) begin
            case (kind)
               BURST_FILL: begin
                  while (shadow_count < LIST_DEPTH) send_op(OP_ADD, pick_id());
                  repeat ($urandom_range(1, 3)) send_op(OP_ADD, pick_id());
               end
               BURST_DRAIN: begin
                  while (shadow_count > 0) begin
                     roll = $urandom_range(99);
                     if (roll < 80) send_op(OP_REMOVE, listed_id());
                     else if (roll < 90) send_op(OP_SELECT, 16'($urandom));
                     else send_op(OP_REMOVE, absent_id());
                  end
                  send_op(OP_SELECT, 16'($urandom));
                  send_op(OP_REMOVE, pick_id());
               end
               default: begin
                  n = $urandom_range(20, 60);
                  repeat (n) begin
                     roll = $urandom_range(99);
                     if (roll < 35) send_op(OP_ADD, pick_id());
                     else if (roll < 60 && shadow_count > 0)
                        send_op(OP_REMOVE, listed_id());
                     else if (roll < 65) send_op(OP_REMOVE, absent_id());
                     else if (roll < 95) send_op(OP_SELECT, 16'($urandom));
                     else send_op(OP_UNUSED, 16'($urandom));
                  end
               end
            endcase
            roll = $urandom_range(99);
            kind = (roll < 20) ? BURST_FILL : (roll < 45) ? BURST_DRAIN : BURST_MIX;
         end
         // hold off the sender until the list has answered everything
         wait_results_drained();
      end

      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && list_results_q.size() == 0) begin
         $display("round_robin_ready_list_top: match");
      end else begin
         $display("round_robin_ready_list_top: mismatch");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("round_robin_ready_list_top: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
